FILE: rtl/framed_ascii_command_recognizer_macros.svh
// Assertion macros used by the checker file.
`ifndef FRAMED_ASCII_COMMAND_RECOGNIZER_MACROS_SVH
`define FRAMED_ASCII_COMMAND_RECOGNIZER_MACROS_SVH

// Implication in the same cycle, ignored while reset is low.
`define FAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, ignored while reset is low.
`define FAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, checked during reset too.
`define FAC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/fac_pkg.sv
// Shared types, constants and text tables of the framed command recognizer.
`timescale 1ns / 1ps
`default_nettype none
package fac_pkg;

    localparam int CMD_CAPACITY_DEF = 32;
    localparam int IN_TDATA_W       = 8;
    localparam int OUT_TDATA_W      = 16;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 8;

    localparam logic [7:0] START_CHAR_RST = 8'h24;
    localparam logic [7:0] STOP_CHAR_RST  = 8'h23;

    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_CHAR  = 1'b1;

    typedef enum logic [1:0] {
        OP_PLAY  = 2'd0,
        OP_PAUSA = 2'd1,
        OP_STOP  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_push;

    function automatic logic [2:0] cmd_len(input t_cmd c);
        logic [2:0] n;
        case (c)
            OP_PLAY:  n = 3'd4;
            OP_PAUSA: n = 3'd5;
            OP_STOP:  n = 3'd4;
            default:  n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] cmd_char(input t_cmd c, input logic [2:0] p);
        logic [39:0] w;
        logic [2:0]  k;
        case (c)
            OP_PLAY:  w = {8'h00, "PLAY"};
            OP_PAUSA: w = "PAUSA";
            OP_STOP:  w = {8'h00, "STOP"};
            default:  w = '0;
        endcase
        k = cmd_len(c) - 3'd1 - p;
        return w[{k, 3'b000} +: 8];
    endfunction

    function automatic logic [3:0] resp_last(input t_cmd c);
        logic [3:0] n;
        case (c)
            OP_PLAY:  n = 4'd8;
            OP_PAUSA: n = 4'd9;
            OP_STOP:  n = 4'd8;
            default:  n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] resp_char(input t_cmd c, input logic [3:0] idx);
        logic [79:0] w;
        logic [3:0]  k;
        case (c)
            OP_PLAY:  w = {8'h00, "#PLAY_OK$"};
            OP_PAUSA: w = {"#PAUSA", "_OK$"};
            OP_STOP:  w = {8'h00, "#STOP_OK$"};
            default:  w = '0;
        endcase
        k = resp_last(c) - idx;
        return w[{k, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/framed_ascii_command_recognizer.sv
// Top level of the framed ASCII command recognizer.
// Usage:
//   Slave stream (i_s_*): one received byte per request. Bytes outside a frame are
//   dropped except the start character; inside a frame bytes are matched against
//   PLAY, PAUSA and STOP until the stop character closes the frame.
//   Master stream (o_m_*): one response byte per request with the lamp state;
//   tlast marks the final byte of the "#<command>_OK$" reply string.
//   Config channel (i_cfg_*): index 0 start character, index 1 stop character.
// Timing:
//   Input takes one byte per cycle while the two-entry command queue has room.
//   The closing byte writes its command into the queue; the back end pops it, enters
//   its send state and registers the first byte, then streams at one byte per cycle
//   while i_m_tready is high, 9 or 10 bytes, and returns to idle to pop the next one.
// Reset clears the frame tracker, the queue and the output valid flag, and loads
// the start and stop characters with '$' and '#'.
// A stall on the master side holds the output register; the queue fills and
// o_s_tready drops only when two further commands wait behind the one in flight.
`timescale 1ns / 1ps
`default_nettype none
module framed_ascii_command_recognizer #(
    parameter int CMD_CAPACITY = fac_pkg::CMD_CAPACITY_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [fac_pkg::IN_TDATA_W-1:0]   i_s_tdata,   // [7:0] rx_byte
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [fac_pkg::OUT_TDATA_W-1:0]       o_m_tdata,   // [7:0] tx_byte, [9:8] lamp_state
    output logic                                  o_m_tlast,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [fac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fac_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    fac_pkg::t_cmd_push push;
    fac_pkg::t_cmd      head;
    logic               fifo_full, fifo_empty, pop;

    fac_front #(
        .CMD_CAPACITY(CMD_CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fifo_full (fifo_full),
        .o_push      (push)
    );

    fac_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_head  (head)
    );

    fac_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (fifo_empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

FILE: rtl/fac_front.sv
// Front end: frame tracking, incremental command matching, configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module fac_front #(
    parameter int CMD_CAPACITY = fac_pkg::CMD_CAPACITY_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [fac_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [fac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fac_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_fifo_full,
    output fac_pkg::t_cmd_push                    o_push
);
    localparam int LEN_W = $clog2(CMD_CAPACITY);

    logic [7:0]       r_start, r_stop;
    logic             r_in_frame, n_in_frame;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_too_long, n_too_long;
    logic             r_m_play, r_m_pausa, r_m_stop;
    logic             n_m_play, n_m_pausa, n_m_stop;
    logic             accept;
    logic [7:0]       b;

    assign o_s_tready  = !i_fifo_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_tvalid && o_s_tready;
    assign b           = i_s_tdata;

    always_comb begin
        n_in_frame  = r_in_frame;
        n_len       = r_len;
        n_too_long  = r_too_long;
        n_m_play    = r_m_play;
        n_m_pausa   = r_m_pausa;
        n_m_stop    = r_m_stop;
        o_push      = '{valid: 1'b0, cmd: fac_pkg::OP_PLAY};
        if (accept) begin
            if (!r_in_frame) begin
                if (b == r_start) begin
                    n_in_frame = 1'b1;
                    n_len      = '0;
                    n_too_long = 1'b0;
                    n_m_play   = 1'b1;
                    n_m_pausa  = 1'b1;
                    n_m_stop   = 1'b1;
                end
            end else if (b != r_stop) begin
                if (r_len < LEN_W'(CMD_CAPACITY - 1)) begin
                    n_len     = r_len + 1'b1;
                    n_m_play  = r_m_play
                        && (r_len < LEN_W'(fac_pkg::cmd_len(fac_pkg::OP_PLAY)))
                        && (b == fac_pkg::cmd_char(fac_pkg::OP_PLAY, r_len[2:0]));
                    n_m_pausa = r_m_pausa
                        && (r_len < LEN_W'(fac_pkg::cmd_len(fac_pkg::OP_PAUSA)))
                        && (b == fac_pkg::cmd_char(fac_pkg::OP_PAUSA, r_len[2:0]));
                    n_m_stop  = r_m_stop
                        && (r_len < LEN_W'(fac_pkg::cmd_len(fac_pkg::OP_STOP)))
                        && (b == fac_pkg::cmd_char(fac_pkg::OP_STOP, r_len[2:0]));
                end else begin
                    n_too_long = 1'b1;
                end
            end else begin
                n_in_frame = 1'b0;
                n_len      = '0;
                n_too_long = 1'b0;
                if (!r_too_long) begin
                    if (r_m_play
                        && r_len == LEN_W'(fac_pkg::cmd_len(fac_pkg::OP_PLAY))) begin
                        o_push = '{valid: 1'b1, cmd: fac_pkg::OP_PLAY};
                    end else if (r_m_pausa
                        && r_len == LEN_W'(fac_pkg::cmd_len(fac_pkg::OP_PAUSA))) begin
                        o_push = '{valid: 1'b1, cmd: fac_pkg::OP_PAUSA};
                    end else if (r_m_stop
                        && r_len == LEN_W'(fac_pkg::cmd_len(fac_pkg::OP_STOP))) begin
                        o_push = '{valid: 1'b1, cmd: fac_pkg::OP_STOP};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= fac_pkg::START_CHAR_RST;
            r_stop     <= fac_pkg::STOP_CHAR_RST;
            r_in_frame <= 1'b0;
            r_len      <= '0;
            r_too_long <= 1'b0;
            r_m_play   <= 1'b0;
            r_m_pausa  <= 1'b0;
            r_m_stop   <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_len      <= n_len;
            r_too_long <= n_too_long;
            r_m_play   <= n_m_play;
            r_m_pausa  <= n_m_pausa;
            r_m_stop   <= n_m_stop;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fac_pkg::REG_START_CHAR: r_start <= i_cfg_data;
                    fac_pkg::REG_STOP_CHAR:  r_stop  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fac_cmd_fifo.sv
// Two-entry queue of recognized commands between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module fac_cmd_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fac_pkg::t_cmd_push i_push,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output fac_pkg::t_cmd           o_head
);
    fac_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fac_back.sv
// Back end: plays out the response string of one command into the output register.
`timescale 1ns / 1ps
`default_nettype none
module fac_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_empty,
    input  wire fac_pkg::t_cmd                     i_head,
    output logic                                   o_pop,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [fac_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    output logic                                   o_m_tlast
);
    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    t_state        r_state;
    fac_pkg::t_cmd r_cmd;
    logic [3:0]    r_idx;
    logic          r_valid;
    logic [7:0]    r_byte;
    logic [1:0]    r_lamp;
    logic          r_last;
    logic          at_last;

    assign o_pop      = (r_state == ST_IDLE) && !i_empty;
    assign at_last    = (r_idx == fac_pkg::resp_last(r_cmd));
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {6'd0, r_lamp, r_byte};
    assign o_m_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_m_tready) begin
                        r_valid <= 1'b0;
                    end
                    if (!i_empty) begin
                        r_state <= ST_SEND;
                        r_cmd   <= i_head;
                        r_idx   <= 4'd0;
                    end
                end
                ST_SEND: begin
                    if (!r_valid || i_m_tready) begin
                        r_valid <= 1'b1;
                        r_byte  <= fac_pkg::resp_char(r_cmd, r_idx);
                        r_lamp  <= 2'(r_cmd);
                        r_last  <= at_last;
                        if (at_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 4'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fac_checker.sv
// Port-level checker of the command recognizer and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "framed_ascii_command_recognizer_macros.svh"
module fac_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [fac_pkg::OUT_TDATA_W-1:0]  i_out_data,
    input wire logic                             i_out_last
);
    `FAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data) && $stable(i_out_last))
    `FAC_ASSERT_IMPL(a_lamp_range, i_clk, i_rst_n, i_out_valid, i_out_data[9:8] != 2'd3 && i_out_data[15:10] == 6'd0)
    `FAC_ASSERT_NEXT(a_lamp_run, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last, !i_out_valid || i_out_data[9:8] == $past(i_out_data[9:8]))
    `FAC_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind framed_ascii_command_recognizer fac_checker u_fac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_m_tvalid),
    .i_out_ready (i_m_tready),
    .i_out_data  (o_m_tdata),
    .i_out_last  (o_m_tlast)
);
`default_nettype wire
